// ===== hdl/pfd_pkg.sv =====
// Package for periodic_field_from_density: payload types, fixed-point widths, microcode ROM.
`timescale 1ns / 1ps
`default_nettype none

package pfd_pkg;

   // ---- fixed-point widths ----
   localparam int SAMPLE_W = 24;   // Q4.20 unsigned sample
   localparam int GAIN_W   = 24;   // Q8.16 signed gain
   localparam int FIELD_W  = 48;   // Q28.20 signed field
   localparam int POS_W    = 6;    // position field on the result
   localparam int ROWSUM_W = 32;   // per-position sum
   localparam int TOTAL_W  = 40;   // grand total
   localparam int FTOT_W   = 56;   // sum of field values
   localparam int AVG_W    = 32;   // average density
   localparam int DIFF_W   = AVG_W + 1;
   localparam int PROD_W   = DIFF_W + GAIN_W;
   localparam int RND_SH   = 16;   // Q.36 -> Q.20
   localparam int RND_W    = PROD_W - RND_SH;

   localparam logic signed [GAIN_W-1:0] GAIN_RESET = 24'sd65536;   // 1.0

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                final_sample;
   } req_payload_type;

   typedef struct packed {
      logic [POS_W-1:0]          position;
      logic signed [FIELD_W-1:0] field_value;
      logic                      last_position;
   } rsp_payload_type;

   // ---- microcode ----
   localparam int STEP_W = 3;

   localparam logic [STEP_W-1:0] STEP_LOAD       = 3'd0;
   localparam logic [STEP_W-1:0] STEP_SETUP      = 3'd1;
   localparam logic [STEP_W-1:0] STEP_READ_ROW   = 3'd2;
   localparam logic [STEP_W-1:0] STEP_MULT       = 3'd3;
   localparam logic [STEP_W-1:0] STEP_INTEG      = 3'd4;
   localparam logic [STEP_W-1:0] STEP_MEAN       = 3'd5;
   localparam logic [STEP_W-1:0] STEP_READ_FIELD = 3'd6;
   localparam logic [STEP_W-1:0] STEP_EMIT       = 3'd7;

   typedef enum logic [2:0] {
      OP_LOAD,
      OP_SETUP,
      OP_READ_ROW,
      OP_MULT,
      OP_INTEG,
      OP_MEAN,
      OP_READ_FIELD,
      OP_EMIT
   } op_type;

   typedef enum logic [1:0] {
      JMP_NEXT,        // fall through to step + 1
      JMP_NOT_FINAL,   // to target unless the request carried the final mark
      JMP_NOT_LAST     // to target unless the index is at the last position
   } jump_type;

   typedef struct packed {
      logic              wait_req;   // step consumes a request
      logic              wait_rsp;   // step needs the result register free
      op_type            op;
      jump_type          jump;
      logic [STEP_W-1:0] target;
   } ctrl_word_type;

   function automatic ctrl_word_type ucode_rom(input logic [STEP_W-1:0] addr);
      ctrl_word_type cw;
      unique case (addr)
         STEP_LOAD:       cw = '{1'b1, 1'b0, OP_LOAD,       JMP_NOT_FINAL, STEP_LOAD};
         STEP_SETUP:      cw = '{1'b0, 1'b0, OP_SETUP,      JMP_NEXT,      STEP_LOAD};
         STEP_READ_ROW:   cw = '{1'b0, 1'b0, OP_READ_ROW,   JMP_NEXT,      STEP_LOAD};
         STEP_MULT:       cw = '{1'b0, 1'b0, OP_MULT,       JMP_NEXT,      STEP_LOAD};
         STEP_INTEG:      cw = '{1'b0, 1'b0, OP_INTEG,      JMP_NOT_LAST,  STEP_READ_ROW};
         STEP_MEAN:       cw = '{1'b0, 1'b0, OP_MEAN,       JMP_NEXT,      STEP_LOAD};
         STEP_READ_FIELD: cw = '{1'b0, 1'b0, OP_READ_FIELD, JMP_NEXT,      STEP_LOAD};
         // falls through from the last step back to the load step
         STEP_EMIT:       cw = '{1'b0, 1'b1, OP_EMIT,       JMP_NOT_LAST,  STEP_READ_FIELD};
      endcase
      return cw;
   endfunction

   // Clamp a 49-bit value to the signed 48-bit range.
   function automatic logic signed [FIELD_W-1:0] sat_field(input logic signed [FIELD_W:0] v);
      logic signed [FIELD_W-1:0] r;
      if (v[FIELD_W] != v[FIELD_W-1]) begin
         r = v[FIELD_W] ? {1'b1, {(FIELD_W-1){1'b0}}} : {1'b0, {(FIELD_W-1){1'b1}}};
      end else begin
         r = v[FIELD_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/periodic_field_from_density.sv =====
// Top level of periodic_field_from_density: microcoded density load, field integration, emit.
`timescale 1ns / 1ps
`default_nettype none

// Periodic 1-D field from a density grid. Requests carry one Q4.20 sample each, in
// position-major, velocity-minor order; the block keeps a running sum per position and a
// grand total. The request marked final_sample starts a run: the average density (grand
// total >> log2(POSITIONS)) is formed, the field is integrated position by position as
// E[i+1] = sat(E[i] + round(gain * (avg - density[i]))), starting at E[0] = 0, its mean is
// removed and POSITIONS responses follow, one per position, the last flagged. Samples past
// POSITIONS*VELOCITIES in one run are dropped; positions not reached count as zero.
// Timing: while loading, one request per cycle. After the final request the block stalls
// requests for the whole run, longer under any response back-pressure: one setup step, three
// steps per position for integration (row-sum memory read, multiply, accumulate), one mean
// step, and two steps per response (field memory read, output load). A small microcode ROM
// sequences these steps; both memories have one registered read port. The last response can
// still be waiting in the output register while the next grid loads. coupling_gain is the
// only CSR (csr_ready is always high); write it only while the block is idle.
module periodic_field_from_density #(
   parameter int POSITIONS  = 64,   // power of two, 2..64
   parameter int VELOCITIES = 128   // 2..256
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // request channel
   input  wire logic                         req_valid,
   output      logic                         req_stall,
   input  wire pfd_pkg::req_payload_type     req_payload,
   // response channel
   output      logic                         rsp_valid,
   input  wire logic                         rsp_stall,
   output      pfd_pkg::rsp_payload_type     rsp_payload,
   // CSR write: coupling_gain
   input  wire logic                         csr_valid,
   output      logic                         csr_ready,
   input  wire logic [pfd_pkg::GAIN_W-1:0]   csr_data
);

   localparam int IDX_W = $clog2(POSITIONS);
   localparam int ROW_W = $clog2(POSITIONS + 1);
   localparam int COL_W = $clog2(VELOCITIES);

   // ---- sequencer ----
   logic [pfd_pkg::STEP_W-1:0] step_ff, step_in;
   pfd_pkg::ctrl_word_type     cw;
   logic                       out_free;
   logic                       go;
   logic                       cond_taken;

   // ---- datapath registers ----
   logic signed [pfd_pkg::GAIN_W-1:0]  gain_ff;
   logic [ROW_W-1:0]                   row_ff;
   logic [COL_W-1:0]                   col_ff;
   logic [pfd_pkg::ROWSUM_W-1:0]       row_acc_ff, row_acc_in;
   logic [pfd_pkg::TOTAL_W-1:0]        grand_total_ff;
   logic [pfd_pkg::AVG_W-1:0]          avg_ff;
   logic [ROW_W-1:0]                   loaded_ff;
   logic [IDX_W-1:0]                   idx_ff;
   logic                               idx_last;
   logic [pfd_pkg::ROWSUM_W-1:0]       row_rd_ff;
   logic signed [pfd_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic signed [pfd_pkg::FIELD_W-1:0] acc_ff, acc_in;
   logic signed [pfd_pkg::FTOT_W-1:0]  field_total_ff;
   logic signed [pfd_pkg::FIELD_W-1:0] mean_ff;
   logic signed [pfd_pkg::FIELD_W-1:0] field_rd_ff;
   logic                               rsp_valid_ff;
   pfd_pkg::rsp_payload_type           rsp_payload_ff, rsp_payload_in;

   // ---- memories ----
   logic [pfd_pkg::ROWSUM_W-1:0]       row_sums [POSITIONS];
   logic signed [pfd_pkg::FIELD_W-1:0] field_store [POSITIONS];

   // ---- combinational helpers ----
   logic                               row_open;
   logic [pfd_pkg::ROWSUM_W-1:0]       local_sum;
   logic signed [pfd_pkg::DIFF_W-1:0]  diff;
   logic signed [pfd_pkg::RND_W-1:0]   rnd;
   logic signed [pfd_pkg::FTOT_W-1:0]  mean_full;

   assign cw       = pfd_pkg::ucode_rom(step_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign go       = (!cw.wait_req || req_valid) && (!cw.wait_rsp || out_free);
   assign idx_last = (idx_ff == IDX_W'(POSITIONS - 1));

   assign req_stall   = !cw.wait_req;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;
   assign csr_ready   = 1'b1;

   // next step: conditional jumps go to target, else fall through
   always_comb begin
      unique case (cw.jump)
         pfd_pkg::JMP_NOT_FINAL: cond_taken = !req_payload.final_sample;
         pfd_pkg::JMP_NOT_LAST:  cond_taken = !idx_last;
         default:                cond_taken = 1'b0;
      endcase
      if (!go) begin
         step_in = step_ff;
      end else if (cond_taken) begin
         step_in = cw.target;
      end else begin
         step_in = step_ff + 1'b1;
      end
   end

   // load path
   assign row_open   = (row_ff < ROW_W'(POSITIONS));
   assign row_acc_in = (col_ff == '0) ? pfd_pkg::ROWSUM_W'(req_payload.sample)
                                      : row_acc_ff + pfd_pkg::ROWSUM_W'(req_payload.sample);

   // integration path; positions not loaded this run read as zero
   assign local_sum = (ROW_W'(idx_ff) < loaded_ff) ? row_rd_ff : '0;
   assign diff      = $signed({1'b0, avg_ff}) - $signed({1'b0, local_sum});
   assign prod_in   = pfd_pkg::PROD_W'(diff) * pfd_pkg::PROD_W'(gain_ff);
   assign rnd       = pfd_pkg::RND_W'((prod_ff + pfd_pkg::PROD_W'(32768)) >>> pfd_pkg::RND_SH);
   assign acc_in    = pfd_pkg::sat_field((pfd_pkg::FIELD_W + 1)'(acc_ff)
                                         + (pfd_pkg::FIELD_W + 1)'(rnd));

   // mean with round-half-up, floor shift
   assign mean_full = (field_total_ff + pfd_pkg::FTOT_W'(POSITIONS / 2)) >>> IDX_W;

   always_comb begin
      rsp_payload_in.position      = pfd_pkg::POS_W'(idx_ff);
      rsp_payload_in.field_value   = pfd_pkg::sat_field((pfd_pkg::FIELD_W + 1)'(field_rd_ff)
                                                        - (pfd_pkg::FIELD_W + 1)'(mean_ff));
      rsp_payload_in.last_position = idx_last;
   end

   // ---- CSR ----
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= pfd_pkg::GAIN_RESET;
      end else if (csr_valid && csr_ready) begin
         gain_ff <= $signed(csr_data);
      end
   end

   // ---- sequencer and datapath ----
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff        <= pfd_pkg::STEP_LOAD;
         row_ff         <= '0;
         col_ff         <= '0;
         grand_total_ff <= '0;
         field_total_ff <= '0;
         idx_ff         <= '0;
      end else begin
         step_ff <= step_in;
         if (go) begin
            unique case (cw.op)
               pfd_pkg::OP_LOAD: begin
                  if (row_open) begin
                     row_acc_ff     <= row_acc_in;
                     grand_total_ff <= grand_total_ff
                                       + pfd_pkg::TOTAL_W'(req_payload.sample);
                     if (col_ff == COL_W'(VELOCITIES - 1)) begin
                        col_ff <= '0;
                        row_ff <= row_ff + 1'b1;
                     end else begin
                        col_ff <= col_ff + 1'b1;
                     end
                  end
               end
               pfd_pkg::OP_SETUP: begin
                  avg_ff         <= pfd_pkg::AVG_W'(grand_total_ff >> IDX_W);
                  loaded_ff      <= row_ff + ROW_W'(col_ff != '0);
                  grand_total_ff <= '0;
                  row_ff         <= '0;
                  col_ff         <= '0;
                  idx_ff         <= '0;
                  acc_ff         <= '0;
                  field_total_ff <= '0;
               end
               pfd_pkg::OP_READ_ROW: begin
               end
               pfd_pkg::OP_MULT: begin
                  prod_ff <= prod_in;
               end
               pfd_pkg::OP_INTEG: begin
                  field_total_ff <= field_total_ff + pfd_pkg::FTOT_W'(acc_ff);
                  acc_ff         <= acc_in;
                  idx_ff         <= idx_ff + 1'b1;
               end
               pfd_pkg::OP_MEAN: begin
                  mean_ff <= mean_full[pfd_pkg::FIELD_W-1:0];
                  idx_ff  <= '0;
               end
               pfd_pkg::OP_READ_FIELD: begin
               end
               pfd_pkg::OP_EMIT: begin
                  idx_ff <= idx_ff + 1'b1;
               end
            endcase
         end
      end
   end

   // row-sum memory: write-through of the running row sum, registered read
   always_ff @(posedge clock) begin
      if (go && cw.op == pfd_pkg::OP_LOAD && row_open) begin
         row_sums[row_ff[IDX_W-1:0]] <= row_acc_in;
      end
      if (go && cw.op == pfd_pkg::OP_READ_ROW) begin
         row_rd_ff <= row_sums[idx_ff];
      end
   end

   // field memory: E[i] stored before the accumulator moves on, registered read
   always_ff @(posedge clock) begin
      if (go && cw.op == pfd_pkg::OP_INTEG) begin
         field_store[idx_ff] <= acc_ff;
      end
      if (go && cw.op == pfd_pkg::OP_READ_FIELD) begin
         field_rd_ff <= field_store[idx_ff];
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (go && cw.op == pfd_pkg::OP_EMIT) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (go && cw.op == pfd_pkg::OP_EMIT) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   // ---- assertions ----
   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      row_ff <= ROW_W'(POSITIONS))
      else $error("row counter past position count");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(step_ff == pfd_pkg::STEP_EMIT))
      else $error("response raised outside the emit step");

   a_setup_clears: assert property (@(posedge clock) disable iff (reset)
      (step_ff == pfd_pkg::STEP_READ_ROW && $past(step_ff == pfd_pkg::STEP_SETUP))
      |-> (grand_total_ff == '0 && row_ff == '0 && col_ff == '0))
      else $error("load state not cleared at run start");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_payload_ff.last_position)
      |-> (rsp_payload_ff.position == pfd_pkg::POS_W'(POSITIONS - 1)))
      else $error("last flag on wrong position");

endmodule

`default_nettype wire

// ===== sim/periodic_field_from_density_test.sv =====
// Self-checking testbench for periodic_field_from_density: random grids, field prediction.
`timescale 1ns / 1ps

module periodic_field_from_density_test;

   localparam int POSITIONS  = 64;
   localparam int VELOCITIES = 128;
   localparam int POS_SHIFT  = $clog2(POSITIONS);

   localparam longint FIELD_MAX = 64'sh7FFF_FFFF_FFFF;
   localparam longint FIELD_MIN = -FIELD_MAX - 1;

   localparam logic [pfd_pkg::GAIN_W-1:0] GAIN_MOST_NEG = 24'h80_0000;   // -128.0
   localparam logic [pfd_pkg::GAIN_W-1:0] GAIN_MOST_POS = 24'h7F_FFFF;   // just under +128.0
   localparam logic [pfd_pkg::GAIN_W-1:0] GAIN_UNITY    = 24'h01_0000;
   localparam logic [pfd_pkg::GAIN_W-1:0] GAIN_ZERO     = 24'h00_0000;

   localparam logic [pfd_pkg::SAMPLE_W-1:0] SAMPLE_MAX = 24'hFF_FFFF;

   localparam int HOLD_OFF_CYCLES = 1500;   // long enough to outlast a whole run

   // ---------------------------------------------------------------- DUT wiring
   logic                             clock       = 1'b0;
   logic                             reset       = 1'b1;
   logic                             req_valid   = 1'b0;
   logic                             req_stall;
   pfd_pkg::req_payload_type         req_payload = '0;
   logic                             rsp_valid;
   logic                             rsp_stall   = 1'b0;
   pfd_pkg::rsp_payload_type         rsp_payload;
   logic                             csr_valid   = 1'b0;
   logic                             csr_ready;
   logic [pfd_pkg::GAIN_W-1:0]       csr_data    = '0;

   periodic_field_from_density #(
      .POSITIONS  (POSITIONS),
      .VELOCITIES (VELOCITIES)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------- shared state
   pfd_pkg::req_payload_type sample_q[$];       // requests not yet offered to the block
   pfd_pkg::rsp_payload_type field_expect_q[$]; // field values still owed by the block

   int send_idle_pct  = 0;   // chance per cycle that the sender holds back
   int recv_stall_pct = 0;   // chance per cycle that the receiver stalls
   int mismatches     = 0;

   // long receiver hold-off: stimulus bumps hold_requests, hold process counts it out
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;

   // ---------------------------------------------------------------- density/field model
   logic signed [pfd_pkg::GAIN_W-1:0] gain_setting = GAIN_UNITY;   // value after reset
   logic [pfd_pkg::ROWSUM_W-1:0]      density_mem[POSITIONS];
   logic [pfd_pkg::TOTAL_W-1:0]       density_total = '0;
   int                                load_row = 0;
   int                                load_col = 0;

   function automatic longint clamp48(input longint v);
      if (v > FIELD_MAX) return FIELD_MAX;
      if (v < FIELD_MIN) return FIELD_MIN;
      return v;
   endfunction

   // Fold one accepted sample into the density sums; on the final mark integrate the
   // field and queue the POSITIONS values the block owes.
   task automatic absorb_sample(input pfd_pkg::req_payload_type r);
      int                       loaded;
      longint                   gain_val;
      longint                   avg;
      longint                   acc;
      longint                   field_sum;
      longint                   mean;
      longint                   level;
      longint                   prod;
      longint                   integ[POSITIONS];
      pfd_pkg::rsp_payload_type owed;
      // samples past a full grid are dropped, final mark still counts
      if (load_row < POSITIONS) begin
         if (load_col == 0) density_mem[load_row] = pfd_pkg::ROWSUM_W'(r.sample);
         else density_mem[load_row] += pfd_pkg::ROWSUM_W'(r.sample);
         density_total += pfd_pkg::TOTAL_W'(r.sample);
         load_col++;
         if (load_col >= VELOCITIES) begin
            load_col = 0;
            load_row++;
         end
      end
      if (!r.final_sample) return;

      // rows never reached in this run act as zero density
      loaded    = load_row + ((load_col > 0) ? 1 : 0);
      gain_val  = longint'(gain_setting);
      avg       = longint'(density_total >> POS_SHIFT);
      acc       = 0;
      field_sum = 0;
      for (int i = 0; i < POSITIONS; i++) begin
         level     = (i < loaded) ? longint'(density_mem[i]) : 0;
         prod      = gain_val * (avg - level);               // Q.36
         integ[i]  = acc;
         field_sum += acc;
         acc       = clamp48(acc + ((prod + 32768) >>> 16)); // round to Q.20
      end
      mean = (field_sum + POSITIONS / 2) >>> POS_SHIFT;
      for (int i = 0; i < POSITIONS; i++) begin
         owed.position      = pfd_pkg::POS_W'(i);
         owed.field_value   = pfd_pkg::FIELD_W'(clamp48(integ[i] - mean));
         owed.last_position = (i == POSITIONS - 1);
         field_expect_q.push_back(owed);
      end
      density_total = '0;
      load_row      = 0;
      load_col      = 0;
   endtask

   // ---------------------------------------------------------------- request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) absorb_sample(req_payload);
         // payload only moves once the current request is gone
         if (!req_valid || !req_stall) begin
            if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid   <= 1'b1;
               req_payload <= sample_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- long hold-off
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
         hold_left   <= HOLD_OFF_CYCLES;
         hold_served <= hold_requests;
      end
   end

   // ---------------------------------------------------------------- result monitor
   always @(posedge clock) begin : result_monitor
      pfd_pkg::rsp_payload_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (field_expect_q.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result, position %0d field %0d last %0b",
                        $time, rsp_payload.position, rsp_payload.field_value,
                        rsp_payload.last_position);
            end else begin
               want = field_expect_q.pop_front();
               if (rsp_payload.position !== want.position) begin
                  mismatches++;
                  $display("%0t: position expected %0d actual %0d",
                           $time, want.position, rsp_payload.position);
               end
               if (rsp_payload.field_value !== want.field_value) begin
                  mismatches++;
                  $display("%0t: field at position %0d expected %0d actual %0d",
                           $time, want.position, want.field_value,
                           rsp_payload.field_value);
               end
               if (rsp_payload.last_position !== want.last_position) begin
                  mismatches++;
                  $display("%0t: last flag at position %0d expected %0b actual %0b",
                           $time, want.position, want.last_position,
                           rsp_payload.last_position);
               end
            end
         end
         rsp_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
      end
   end

   // ---------------------------------------------------------------- stimulus helpers
   task automatic queue_sample(input logic [pfd_pkg::SAMPLE_W-1:0] s, input logic fin);
      pfd_pkg::req_payload_type r;
      r.sample       = s;
      r.final_sample = fin;
      sample_q.push_back(r);
   endtask

   // skewed toward the extremes so big density swings show up often
   function automatic logic [pfd_pkg::SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(9))
         0, 1:    return SAMPLE_MAX;
         2:       return '0;
         default: return pfd_pkg::SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
      endcase
   endfunction

   task automatic queue_run(input int n);
      for (int k = 0; k < n; k++) queue_sample(pick_sample(), k == n - 1);
   endtask

   // short grids; the last one is trimmed so the count lands on target
   task automatic queue_random_runs(input int target);
      int pushed;
      int n;
      pushed = 0;
      while (pushed < target) begin
         n = $urandom_range(1, 30);
         if (n > target - pushed) n = target - pushed;
         queue_run(n);
         pushed += n;
      end
   endtask

   // only called with the block idle
   task automatic write_gain(input logic [pfd_pkg::GAIN_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      gain_setting = value;
      csr_valid   <= 1'b0;
      @(negedge clock);
   endtask

   // all requests taken and all field values back, then a short settle
   task automatic wait_idle(input int settle);
      while (sample_q.size() != 0 || req_valid || field_expect_q.size() != 0)
         @(negedge clock);
      repeat (settle) @(posedge clock);
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------- test sequence
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset gain, final on the very first sample, field extremes
      queue_sample(SAMPLE_MAX, 1'b1);
      queue_sample('0, 1'b0);
      queue_sample(24'h00_0001, 1'b0);
      queue_sample(24'h80_0000, 1'b0);
      queue_sample(24'h7F_FFFF, 1'b0);
      queue_sample(SAMPLE_MAX, 1'b1);
      wait_idle(8);

      write_gain(GAIN_MOST_NEG);
      queue_sample(SAMPLE_MAX, 1'b0);
      queue_sample(SAMPLE_MAX, 1'b0);
      queue_sample('0, 1'b1);
      wait_idle(8);

      write_gain(GAIN_MOST_POS);
      queue_sample(SAMPLE_MAX, 1'b0);
      queue_sample(SAMPLE_MAX, 1'b1);
      wait_idle(8);

      write_gain(GAIN_ZERO);
      queue_sample(24'h12_3456, 1'b1);
      wait_idle(8);

      // no idling on either side; one grid crosses into the second position
      write_gain(pfd_pkg::GAIN_W'($urandom_range(0, 24'hFF_FFFF)));
      queue_run(VELOCITIES + 2);
      queue_random_runs(20);
      wait_idle(8);

      // sender mostly idle
      write_gain(GAIN_UNITY);
      send_idle_pct  = 74;
      recv_stall_pct = 0;
      queue_random_runs(20);
      wait_idle(8);

      // receiver mostly stalling
      write_gain(pfd_pkg::GAIN_W'($urandom_range(0, 24'hFF_FFFF)));
      send_idle_pct  = 0;
      recv_stall_pct = 74;
      queue_random_runs(20);
      wait_idle(8);

      // both sides idle now and then
      write_gain(pfd_pkg::GAIN_W'($urandom_range(0, 24'h7F_FFFF)));
      send_idle_pct  = 26;
      recv_stall_pct = 26;
      queue_random_runs(20);
      wait_idle(8);

      // back-pressure: receiver holds off while two grids are offered back to back,
      // so the output register fills and the block stalls its request side
      write_gain(GAIN_MOST_POS);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_requests++;
      queue_run(5);
      queue_run(10);
      wait_idle(20);

      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin
      #20_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== periodic_field_from_density.f =====
hdl/pfd_pkg.sv
hdl/periodic_field_from_density.sv
sim/periodic_field_from_density_test.sv
